/* sv/sorted_list_insert_delete_top_defines.svh */
// Assertion macros for the sorted list block.
// They expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SLID_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SLID_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/slid_pkg.sv */
`default_nettype none

package slid_pkg;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] removed_value;
        t_status            status;
        logic [4:0]         entries_held;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_DEL_CAP,
        S_DEL_MOV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/slid_stream_if.sv */
`default_nettype none

interface slid_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/sorted_list_insert_delete_top.sv */
// Sorted list store: one transaction in, one result transaction out.
// Throughput: one command at a time; input is ready again in the cycle after the result is
// loaded, and a result the sink has not taken holds the next command in the done state.
// Reset (synchronous, active low) empties the list and drops any pending result.
`default_nettype none

`include "sorted_list_insert_delete_top_defines.svh"

module sorted_list_insert_delete_top #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    slid_stream_if.sink   i_in,
    slid_stream_if.source o_out
);

    import slid_pkg::*;

    // Index width for the memory, count width able to hold DEPTH itself, and
    // wider work widths for comparisons against the 5-bit position.
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int XW   = CW + 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic [31:0]        r_removed, n_removed;
    t_status            r_status, n_status;
    logic [CW-1:0]      r_count, n_count;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    // Remember which command is in flight so the count can move the right way.
    logic               r_delete;

    logic               in_fire;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;
    logic [XW-1:0]      idx_x;
    logic [CMPW-1:0]    pos_c;
    logic [CMPW-1:0]    cnt_c;

    // The sorted values live in a single memory with a registered read port.
    slid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign idx_x = XW'(r_idx);
    assign pos_c = CMPW'(i_in.data.position);
    assign cnt_c = CMPW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_delete <= (i_in.data.cmd == CMD_DELETE);
        end
    end

    // Insert walks down from the top entry. Each cycle it compares the entry
    // read in the previous cycle with the new value; a larger entry moves up one
    // slot while the read of the next lower entry is issued. Read and write never
    // hit the same address, so no forwarding is needed.
    // Delete reads the named entry, then walks upward moving each later entry
    // down one slot, again with the read running two addresses ahead of the write.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_val       = r_val;
        n_removed   = r_removed;
        n_status    = r_status;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        // The result register frees up as soon as the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_val     = i_in.data.value;
                    n_removed = '0;
                    n_status  = ST_OK;
                    if (i_in.data.cmd == CMD_INSERT) begin
                        if (XW'(r_count) >= XW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            // An empty list takes the value straight into slot zero.
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = i_in.data.value;
                            n_state   = S_DONE;
                        end else begin
                            n_idx     = AW'(r_count - CW'(1));
                            mem_raddr = AW'(r_count - CW'(1));
                            n_state   = S_INS_CMP;
                        end
                    end else begin
                        if (pos_c == '0 || pos_c > cnt_c) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_idx     = AW'(pos_c - CMPW'(1));
                            mem_raddr = AW'(pos_c - CMPW'(1));
                            n_state   = S_DEL_CAP;
                        end
                    end
                end
            end

            S_INS_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_x + XW'(1));
                if ($signed(mem_rdata) > r_val) begin
                    mem_wdata = mem_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx     = r_idx - AW'(1);
                        mem_raddr = r_idx - AW'(1);
                    end
                end else begin
                    // Equal values land after the entries already held.
                    mem_wdata = r_val;
                    n_state   = S_DONE;
                end
            end

            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_val;
                n_state   = S_DONE;
            end

            S_DEL_CAP: begin
                n_removed = mem_rdata;
                if (idx_x + XW'(1) < XW'(r_count)) begin
                    mem_raddr = AW'(idx_x + XW'(1));
                    n_state   = S_DEL_MOV;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DEL_MOV: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                if (idx_x + XW'(2) < XW'(r_count)) begin
                    mem_raddr = AW'(idx_x + XW'(2));
                    n_idx     = r_idx + AW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // The count moves only when the result is loaded, so a held
                // result always matches the count it reports.
                if (!r_out_valid || o_out.ready) begin
                    if (r_status == ST_OK && r_delete) begin
                        n_count = r_count - CW'(1);
                    end else if (r_status == ST_OK) begin
                        n_count = r_count + CW'(1);
                    end
                    n_out.removed_value = $signed(r_removed);
                    n_out.status        = r_status;
                    n_out.entries_held  = 5'(n_count);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The list never holds more than its capacity.
    `SLID_ASSERT_ALWAYS(a_count_bound, XW'(r_count) <= XW'(DEPTH), "count above capacity")
    // A waiting result reports the count the list holds right now.
    `SLID_ASSERT_IMPLY(a_count_matches, r_out_valid, r_out.entries_held == 5'(r_count), "stale count")
    // From idle, the memory is written only by an insert into an empty list.
    `SLID_ASSERT_IMPLY(a_idle_write, mem_we && r_state == S_IDLE, in_fire && r_count == '0, "idle write")

endmodule

`default_nettype wire

/* sv/slid_ram.sv */
`default_nettype none

module slid_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    // One write port and one registered read port.
    logic [31:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sim/tb_sorted_list_insert_delete_top.sv */
`default_nettype none

module tb_sorted_list_insert_delete_top;
    import slid_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_OPS   = 1950;
    localparam int MAX_WAIT     = 15;
    localparam int SETTLE_TICKS = 2 * LIST_DEPTH + 8;
    localparam int MAX_PRINTED  = 200;

    typedef struct {
        t_in_item op;
        int       gap;
        bit       wait_for_drain;
    } t_pending_op;

    logic clk;
    logic rst_n;

    slid_stream_if #(.T(t_in_item))  in_if ();
    slid_stream_if #(.T(t_out_item)) out_if ();

    sorted_list_insert_delete_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Commands waiting to be driven, and results the list is owed.
    t_pending_op pending_ops[$];
    t_out_item   owed_results[$];

    // Shadow copy of the sorted store, updated once per accepted transaction.
    logic signed [31:0] shadow_entries [LIST_DEPTH];
    int                 shadow_count;

    int  mismatch_count;
    int  ops_queued;
    int  ops_accepted;
    int  plan_count;
    bit  sender_calm;
    bit  receiver_calm;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Applies one command to the shadow store and returns the result it owes.
    function automatic t_out_item apply_list_op(input t_in_item op);
        t_out_item res;
        int        slot;
        int        i;
        res.removed_value = '0;
        res.status        = ST_OK;
        if (op.cmd == CMD_INSERT) begin
            if (shadow_count >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // Equal values go after the entries already held.
                slot = 0;
                while (slot < shadow_count && shadow_entries[slot] <= op.value) slot++;
                for (i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[slot] = op.value;
                shadow_count++;
            end
        end else begin
            if (op.position == 5'd0 || int'(op.position) > shadow_count) begin
                res.status = ST_RANGE;
            end else begin
                slot = int'(op.position) - 1;
                res.removed_value = shadow_entries[slot];
                for (i = slot; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
                shadow_count--;
            end
        end
        res.entries_held = 5'(shadow_count);
        return res;
    endfunction

    // Queues one command with a random lead-in gap and tracks the planned fill level.
    task automatic queue_op(input t_cmd cmd, input logic signed [31:0] value,
                            input logic [4:0] position, input bit drain);
        t_pending_op p;
        p.op.cmd         = cmd;
        p.op.value       = value;
        p.op.position    = position;
        p.gap            = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        p.wait_for_drain = drain;
        pending_ops.push_back(p);
        ops_queued++;
        if ($urandom_range(0, 99) == 0) sender_calm = ~sender_calm;
        if (cmd == CMD_INSERT && plan_count < LIST_DEPTH) plan_count++;
        if (cmd == CMD_DELETE && position != 5'd0 && int'(position) <= plan_count) plan_count--;
    endtask

    // Driver: holds a transaction until it is taken, then counts out the next gap.
    t_pending_op next_op;
    bit          have_next;
    int          gap_left;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            have_next = 1'b0;
            gap_left  = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (!have_next && pending_ops.size() > 0) begin
                next_op   = pending_ops.pop_front();
                have_next = 1'b1;
                gap_left  = next_op.gap;
            end
            // A drain hold keeps valid low until the last transaction has been
            // seen leaving and every owed result has come back.
            if (have_next && gap_left == 0 &&
                !(next_op.wait_for_drain && (in_if.valid || owed_results.size() != 0))) begin
                in_if.data  <= next_op.op;
                in_if.valid <= 1'b1;
                have_next = 1'b0;
            end else begin
                in_if.valid <= 1'b0;
                if (have_next && gap_left > 0) gap_left--;
            end
        end
    end

    // Monitor: predicts on every accepted command, checks every accepted result,
    // and stalls the result side for a random number of cycles after each one.
    int stall_left;

    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                owed_results.push_back(apply_list_op(in_if.data));
                ops_accepted++;
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: %0d/%0d/%0d",
                                              got.removed_value, got.status, got.entries_held));
                end else begin
                    want = owed_results.pop_front();
                    if (got.removed_value !== want.removed_value)
                        report_mismatch($sformatf("removed_value %0d, expected %0d",
                                                  got.removed_value, want.removed_value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.entries_held !== want.entries_held)
                        report_mismatch($sformatf("entries_held %0d, expected %0d",
                                                  got.entries_held, want.entries_held));
                end
                stall_left = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 63) == 0) receiver_calm = ~receiver_calm;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_if.ready <= (stall_left == 0);
        end
    end

    initial begin
        int                 n;
        int                 insert_bias;
        logic signed [31:0] v;
        logic [4:0]         pos;

        in_if.valid   = 1'b0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        rst_n         = 1'b0;
        mismatch_count = 0;
        ops_queued    = 0;
        ops_accepted  = 0;
        plan_count    = 0;
        shadow_count  = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        // Directed: deletes on an empty list, extreme and equal values, a full
        // list rejecting an insert, then deletes out of range, at the ends and inside.
        queue_op(CMD_DELETE, '0, 5'd0, 1'b0);
        queue_op(CMD_DELETE, 32'sh7fffffff, 5'd1, 1'b0);
        queue_op(CMD_INSERT, 32'sh7fffffff, 5'd31, 1'b0);
        queue_op(CMD_INSERT, 32'sh80000000, 5'd0, 1'b0);
        queue_op(CMD_INSERT, 32'sd0, 5'd0, 1'b0);
        queue_op(CMD_INSERT, 32'sd0, 5'd0, 1'b0);
        queue_op(CMD_INSERT, -32'sd1, 5'd0, 1'b0);
        while (plan_count < LIST_DEPTH) queue_op(CMD_INSERT, $urandom, 5'($urandom), 1'b0);
        queue_op(CMD_INSERT, 32'sh80000000, 5'd0, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd0, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd31, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd17, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd16, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd1, 1'b0);
        queue_op(CMD_DELETE, '0, 5'd7, 1'b0);

        // Random: phases lean toward filling or emptying so that both the full
        // and the empty list come up often; most deletes name a held entry.
        insert_bias = 50;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_bias = 25;
                    1: insert_bias = 50;
                    default: insert_bias = 80;
                endcase
            end
            if ($urandom_range(0, 99) < insert_bias) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom;
                    4, 5, 6:    v = $urandom_range(0, 16) - 8;
                    default: begin
                        case ($urandom_range(0, 5))
                            0: v = 32'sh80000000;
                            1: v = 32'sh7fffffff;
                            2: v = 32'sh80000001;
                            3: v = 32'sh7ffffffe;
                            4: v = 32'sd0;
                            default: v = -32'sd1;
                        endcase
                    end
                endcase
                queue_op(CMD_INSERT, v, 5'($urandom), n == 0 || $urandom_range(0, 399) == 0);
            end else begin
                if (plan_count > 0 && $urandom_range(0, 99) < 85)
                    pos = 5'($urandom_range(1, plan_count));
                else
                    pos = 5'($urandom_range(0, 31));
                queue_op(CMD_DELETE, $urandom, pos, n == 0 || $urandom_range(0, 399) == 0);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < ops_queued) @(posedge clk);
        while (owed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout guard: ends the run as a mismatch if the test has not finished first.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/slid_pkg.sv
sv/slid_stream_if.sv
sv/slid_ram.sv
sv/sorted_list_insert_delete_top.sv
sim/tb_sorted_list_insert_delete_top.sv
